// ===== sv/nlc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Numeric literal classifier package
// Shared types and codes for the automaton states and the token classes.
// ----------------------------------------------------------------------------
package nlc_pkg;

  typedef enum logic [3:0] {
    P_START  = 4'd0,
    P_ZERO   = 4'd1,
    P_OCT    = 4'd2,
    P_HEXPRE = 4'd3,
    P_HEX    = 4'd4,
    P_DEC    = 4'd5,
    P_DOT    = 4'd6,
    P_FRAC   = 4'd7,
    P_EXP    = 4'd8,
    P_ESIGN  = 4'd9,
    P_EDIG   = 4'd10,
    P_BAD    = 4'd11
  } lex_state_t;

  typedef enum logic [2:0] {
    CLS_DEC  = 3'd0,
    CLS_OCT  = 3'd1,
    CLS_HEX  = 3'd2,
    CLS_FLT  = 3'd3,
    CLS_ZERO = 3'd4,
    CLS_BAD  = 3'd5
  } token_class_t;

  typedef struct packed {
    lex_state_t   state_nxt;
    token_class_t token_class;
  } step_res_t;

endpackage

// ===== sv/nlc_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Numeric literal classifier input channel
// Carries one token byte per transfer, with a flag for the final byte.
// ----------------------------------------------------------------------------
interface nlc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] token_byte;
  logic       last_byte;

  modport source (output valid, output token_byte, output last_byte, input ready);
  modport sink   (input valid, input token_byte, input last_byte, output ready);
endinterface

// ===== sv/nlc_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Numeric literal classifier result channel
// Carries the class of one completed token per transfer.
// ----------------------------------------------------------------------------
interface nlc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] token_class;

  modport source (output valid, output token_class, input ready);
  modport sink   (input valid, input token_class, output ready);
endinterface

// ===== sv/nlc_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Numeric literal classifier step
// Next state of the literal automaton for one byte, and the class that the
// token would have if it ended in that next state.
// ----------------------------------------------------------------------------
module nlc_step
  import nlc_pkg::*;
(
  input  lex_state_t state,
  input  logic [7:0] token_byte,
  output step_res_t  res
);

  logic is_dig;
  logic is_oct;
  logic is_hex;
  logic is_sign;
  logic is_x;
  logic is_e;
  logic is_dot;
  lex_state_t nxt;

  always_comb begin
    is_dig  = token_byte inside {[8'h30:8'h39]};
    is_oct  = token_byte inside {[8'h30:8'h37]};
    is_hex  = token_byte inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
    is_sign = token_byte inside {8'h2b, 8'h2d};
    is_x    = token_byte inside {8'h58, 8'h78};
    is_e    = token_byte inside {8'h45, 8'h65};
    is_dot  = (token_byte == 8'h2e);
  end

  always_comb begin
    nxt = P_BAD;
    case (state)
      P_START: begin
        if (token_byte == 8'h30) nxt = P_ZERO;
        else if (is_dig)         nxt = P_DEC;
      end
      P_ZERO: begin
        if (is_x)        nxt = P_HEXPRE;
        else if (is_oct) nxt = P_OCT;
        else if (is_dot) nxt = P_DOT;
      end
      P_OCT: begin
        if (is_oct)      nxt = P_OCT;
        else if (is_dot) nxt = P_DOT;
      end
      P_HEXPRE, P_HEX: begin
        if (is_hex) nxt = P_HEX;
      end
      P_DEC: begin
        if (is_dig)      nxt = P_DEC;
        else if (is_dot) nxt = P_DOT;
      end
      P_DOT: begin
        if (is_dig) nxt = P_FRAC;
      end
      P_FRAC: begin
        if (is_dig || is_sign) nxt = P_FRAC;
        else if (is_e)         nxt = P_EXP;
      end
      P_EXP: begin
        if (is_sign) nxt = P_ESIGN;
      end
      P_ESIGN, P_EDIG: begin
        if (is_dig) nxt = P_EDIG;
      end
      default: nxt = P_BAD;
    endcase
  end

  always_comb begin
    res.state_nxt = nxt;
    case (nxt)
      P_ZERO:                res.token_class = CLS_ZERO;
      P_OCT:                 res.token_class = CLS_OCT;
      P_HEX:                 res.token_class = CLS_HEX;
      P_DEC:                 res.token_class = CLS_DEC;
      P_DOT, P_FRAC, P_EDIG: res.token_class = CLS_FLT;
      default:               res.token_class = CLS_BAD;
    endcase
  end

endmodule

// ===== sv/numeric_literal_classifier_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Numeric literal classifier unit
// Classifies a trimmed token, fed one byte per transfer, as a numeric literal.
// ----------------------------------------------------------------------------
// The input channel takes one token byte per transfer; last_byte marks the
// final byte of a token. On that byte the result channel offers the class:
// 0 decimal, 1 octal, 2 hex, 3 float, 4 zero, 5 malformed. Bytes that are not
// last give no result.
// Each byte is held in an input register, runs through the automaton step
// from there and, if it ends a token, lands in the result register when that
// register is free. A class is thus offered from the result register after
// its last byte has passed through the input register. One byte is accepted
// every cycle while no final byte waits; the automaton state register closes
// the automaton's loop, one step per cycle while bytes flow.
// While the receiver stalls, the result is held and further non-final bytes
// keep flowing; a final byte waits in the input register until the result
// register frees, and input ready drops only then.
// Synchronous active-low reset returns the automaton to the start of a token
// and empties both registers.
// ----------------------------------------------------------------------------
module numeric_literal_classifier_unit
  import nlc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  nlc_in_if.sink           in_ch,
  nlc_out_if.source        out_ch
);

  logic         in_valid_r;
  logic [7:0]   in_byte_r;
  logic         in_last_r;
  lex_state_t   state_r;
  lex_state_t   state_nxt;
  logic         out_valid_r;
  token_class_t out_class_r;
  step_res_t    res;
  logic         out_free;
  logic         proc_fire;

  nlc_step u_step (
    .state      (state_r),
    .token_byte (in_byte_r),
    .res        (res)
  );

  assign out_free  = !out_valid_r || out_ch.ready;
  assign proc_fire = in_valid_r && (!in_last_r || out_free);
  assign in_ch.ready = !in_valid_r || proc_fire;

  always_comb begin
    state_nxt = state_r;
    if (proc_fire) begin
      state_nxt = in_last_r ? P_START : res.state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= P_START;
    end else begin
      state_r <= state_nxt;
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (proc_fire && in_last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r <= in_ch.token_byte;
      in_last_r <= in_ch.last_byte;
    end
    if (proc_fire && in_last_r) begin
      out_class_r <= res.token_class;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.token_class = out_class_r;

endmodule

// ===== test/numeric_literal_classifier_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Numeric literal classifier unit testbench
// Feeds tokens one byte per transfer and checks every class offered against
// an in-bench model, or a typed row's class. A short table of directed tokens
// covers the edge cases. Random well-formed, damaged and noise tokens follow.
// Both channels idle at random, with calm stretches where neither side idles.
// ----------------------------------------------------------------------------
module numeric_literal_classifier_unit_tb;
  import nlc_pkg::*;

  localparam int RANDOM_BYTES = 1830;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int DIR_ROWS     = 26;

  typedef struct {
    logic [7:0]   ch;
    logic         fin;
    logic         typed;
    token_class_t cls;
  } dir_row_t;

  // Class fields are meaningful only where typed is set.
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{"0", 1'b1, 1'b1, CLS_ZERO},
    '{"9", 1'b1, 1'b1, CLS_DEC},
    '{8'hFF, 1'b1, 1'b1, CLS_BAD},
    '{8'h00, 1'b1, 1'b1, CLS_BAD},
    '{"0", 1'b0, 1'b0, CLS_BAD},
    '{"X", 1'b1, 1'b1, CLS_BAD},
    '{"0", 1'b0, 1'b0, CLS_BAD},
    '{"x", 1'b0, 1'b0, CLS_BAD},
    '{"F", 1'b1, 1'b0, CLS_BAD},
    '{"0", 1'b0, 1'b0, CLS_BAD},
    '{"8", 1'b0, 1'b0, CLS_BAD},
    '{"x", 1'b1, 1'b1, CLS_BAD},
    '{"0", 1'b0, 1'b0, CLS_BAD},
    '{"7", 1'b1, 1'b0, CLS_BAD},
    '{"1", 1'b0, 1'b0, CLS_BAD},
    '{".", 1'b1, 1'b0, CLS_BAD},
    '{"1", 1'b0, 1'b0, CLS_BAD},
    '{".", 1'b0, 1'b0, CLS_BAD},
    '{"e", 1'b1, 1'b1, CLS_BAD},
    '{"7", 1'b0, 1'b0, CLS_BAD},
    '{".", 1'b0, 1'b0, CLS_BAD},
    '{"1", 1'b0, 1'b0, CLS_BAD},
    '{"-", 1'b0, 1'b0, CLS_BAD},
    '{"e", 1'b0, 1'b0, CLS_BAD},
    '{"+", 1'b0, 1'b0, CLS_BAD},
    '{"8", 1'b1, 1'b0, CLS_BAD}
  };

  logic clk;
  logic rst_n;

  nlc_in_if  in_ch ();
  nlc_out_if out_ch ();

  numeric_literal_classifier_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  lex_state_t   tok_state;
  token_class_t class_due_q [$];
  token_class_t due_cls;
  logic [7:0]   tok_q [$];
  bit           calm;
  int           mismatch_cnt;
  int           quiet_cycles;
  int           bytes_sent;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_sign(logic [7:0] c);
    return c == "+" || c == "-";
  endfunction

  function automatic lex_state_t lex_next(lex_state_t s, logic [7:0] c);
    case (s)
      P_START: begin
        if (c == "0") return P_ZERO;
        if (c >= "1" && c <= "9") return P_DEC;
        return P_BAD;
      end
      P_ZERO: begin
        if (c == "x" || c == "X") return P_HEXPRE;
        if (c >= "0" && c <= "7") return P_OCT;
        if (c == ".") return P_DOT;
        return P_BAD;
      end
      P_OCT: begin
        if (c >= "0" && c <= "7") return P_OCT;
        if (c == ".") return P_DOT;
        return P_BAD;
      end
      P_HEXPRE, P_HEX: begin
        if (is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F")) return P_HEX;
        return P_BAD;
      end
      P_DEC: begin
        if (is_digit(c)) return P_DEC;
        if (c == ".") return P_DOT;
        return P_BAD;
      end
      P_DOT: return is_digit(c) ? P_FRAC : P_BAD;
      P_FRAC: begin
        if (is_digit(c) || is_sign(c)) return P_FRAC;
        if (c == "e" || c == "E") return P_EXP;
        return P_BAD;
      end
      P_EXP: return is_sign(c) ? P_ESIGN : P_BAD;
      P_ESIGN, P_EDIG: return is_digit(c) ? P_EDIG : P_BAD;
      default: return P_BAD;
    endcase
  endfunction

  function automatic token_class_t class_for(lex_state_t s);
    case (s)
      P_ZERO: return CLS_ZERO;
      P_OCT: return CLS_OCT;
      P_HEX: return CLS_HEX;
      P_DEC: return CLS_DEC;
      P_DOT, P_FRAC, P_EDIG: return CLS_FLT;
      default: return CLS_BAD;
    endcase
  endfunction

  function automatic logic [7:0] pick(string set);
    return set[$urandom_range(0, set.len() - 1)];
  endfunction

  // Entered and left at a falling edge.
  task automatic send_byte(logic [7:0] ch, logic fin, logic typed, token_class_t cls);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.token_byte <= ch;
    in_ch.last_byte  <= fin;
    do @(posedge clk); while (!in_ch.ready);
    tok_state = lex_next(tok_state, ch);
    if (fin) begin
      class_due_q.push_back(typed ? cls : class_for(tok_state));
      tok_state = P_START;
    end
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic make_good(int kind);
    int prefix;
    tok_q.delete();
    case (kind)
      0: tok_q.push_back("0");
      1: begin
        tok_q.push_back("0");
        repeat ($urandom_range(1, 4)) tok_q.push_back(pick("01234567"));
      end
      2: begin
        tok_q.push_back("0");
        tok_q.push_back(pick("xX"));
        repeat ($urandom_range(1, 4)) tok_q.push_back(pick("0123456789abcdefABCDEF"));
      end
      3: begin
        tok_q.push_back(pick("123456789"));
        repeat ($urandom_range(0, 4)) tok_q.push_back(pick("0123456789"));
      end
      default: begin
        prefix = $urandom_range(0, 2);
        if (prefix == 2) begin
          tok_q.push_back(pick("123456789"));
          repeat ($urandom_range(0, 3)) tok_q.push_back(pick("0123456789"));
        end else begin
          tok_q.push_back("0");
          if (prefix == 1) repeat ($urandom_range(1, 3)) tok_q.push_back(pick("01234567"));
        end
        tok_q.push_back(".");
        if ($urandom_range(0, 3) != 0) begin
          tok_q.push_back(pick("0123456789"));
          repeat ($urandom_range(0, 4)) tok_q.push_back(pick("0123456789+-"));
          if ($urandom_range(0, 1) != 0) begin
            tok_q.push_back(pick("eE"));
            tok_q.push_back(pick("+-"));
            repeat ($urandom_range(1, 3)) tok_q.push_back(pick("0123456789"));
          end
        end
      end
    endcase
  endtask

  task automatic build_token();
    int kind;
    int idx;
    int keep;
    kind = $urandom_range(0, 9);
    if (kind <= 5) begin
      make_good(kind);
    end else if (kind <= 7) begin
      make_good($urandom_range(0, 5));
      idx = $urandom_range(0, tok_q.size() - 1);
      if ($urandom_range(0, 1) != 0) tok_q[idx] = pick("0789aAfFgxXeE+-. ");
      else tok_q[idx] = 8'($urandom_range(0, 255));
    end else if (kind == 8) begin
      tok_q.delete();
      repeat ($urandom_range(1, 5)) tok_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      make_good(4);
      keep = $urandom_range(1, tok_q.size());
      while (tok_q.size() > keep) void'(tok_q.pop_back());
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (class_due_q.size() == 0) begin
        $display("%0t: unexpected token_class, expected none, actual %0d",
                 $time, out_ch.token_class);
        mismatch_cnt++;
      end else begin
        due_cls = class_due_q.pop_front();
        if (out_ch.token_class !== due_cls) begin
          $display("%0t: token_class mismatch, expected %0d, actual %0d",
                   $time, due_cls, out_ch.token_class);
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      @(negedge clk);
    end
  end

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.token_byte = 8'h00;
    in_ch.last_byte  = 1'b0;
    tok_state        = P_START;
    calm             = 1'b0;
    mismatch_cnt     = 0;
    quiet_cycles     = 0;
    bytes_sent       = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_byte(dir_tab[i].ch, dir_tab[i].fin, dir_tab[i].typed, dir_tab[i].cls);
    end

    while (bytes_sent < RANDOM_BYTES + DIR_ROWS) begin
      if ($urandom_range(0, 15) == 0) calm = ~calm;
      build_token();
      for (int i = 0; i < tok_q.size(); i++) begin
        send_byte(tok_q[i], i == tok_q.size() - 1, 1'b0, CLS_BAD);
      end
    end
    in_ch.valid <= 1'b0;

    while (class_due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && class_due_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/nlc_pkg.sv
sv/nlc_in_if.sv
sv/nlc_out_if.sv
sv/nlc_step.sv
sv/numeric_literal_classifier_unit.sv
test/numeric_literal_classifier_unit_tb.sv
